/* hw/rtl/pdrt_pkg.sv */
// Shared constants, codes and types of the presence debounce and rule trigger block.
`default_nettype none

package pdrt_pkg;

    // Field widths
    localparam int SLOT_W      = 3;
    localparam int TARGET_W    = 8;
    localparam int DUR_W       = 16;
    localparam int AGE_W       = 32;
    localparam int PEND_W      = 8;
    localparam int RC_W        = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Default rule table depth
    localparam int RULES_DEFAULT = 8;

    // Register reset values
    localparam logic [PEND_W-1:0] DEBOUNCE_RESET   = 8'd10;
    localparam logic [RC_W-1:0]   RULE_COUNT_RESET = 4'd0;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_COUNT = 2'd1;

    // Input commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_FIRE   = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;

    // Presence report codes
    localparam logic [1:0] REP_NONE    = 2'd0;
    localparam logic [1:0] REP_UNAVAIL = 2'd1;
    localparam logic [1:0] REP_PRESENT = 2'd2;
    localparam logic [1:0] REP_ABSENT  = 2'd3;

    // One rule slot
    typedef struct packed {
        logic              enabled;
        logic              on_absence;
        logic [DUR_W-1:0]  duration;
        logic [TARGET_W-1:0] target;
    } rule_t;

    // Control from the sequencer to the rule unit
    typedef struct packed {
        logic wr_en;
        logic arm_all;
        logic arm_first;
        logic step_en;
    } rule_ctl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/pdrt_req_if.sv */
// Input item channel: ticks and rule loads.
`default_nettype none

interface pdrt_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic                          sensor_alive;
    logic                          sensor_raw;
    logic                          link_ready;
    logic [pdrt_pkg::SLOT_W-1:0]   slot_index;
    logic                          slot_enabled;
    logic                          slot_on_absence;
    logic [pdrt_pkg::DUR_W-1:0]    slot_duration;
    logic [pdrt_pkg::TARGET_W-1:0] slot_target;

    modport source (
        output valid, cmd, sensor_alive, sensor_raw, link_ready, slot_index,
               slot_enabled, slot_on_absence, slot_duration, slot_target,
        input  ready
    );
    modport sink (
        input  valid, cmd, sensor_alive, sensor_raw, link_ready, slot_index,
               slot_enabled, slot_on_absence, slot_duration, slot_target,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/pdrt_rsp_if.sv */
// Result item channel: reports, fired rules and load acknowledgements.
`default_nettype none

interface pdrt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [1:0]                    presence_report;
    logic                          debounced_present;
    logic [pdrt_pkg::AGE_W-1:0]    present_seconds;
    logic [pdrt_pkg::SLOT_W-1:0]   fired_slot;
    logic [pdrt_pkg::TARGET_W-1:0] fired_target;
    logic                          last;

    modport source (
        output valid, kind, presence_report, debounced_present, present_seconds,
               fired_slot, fired_target, last,
        input  ready
    );
    modport sink (
        input  valid, kind, presence_report, debounced_present, present_seconds,
               fired_slot, fired_target, last,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/pdrt_cfg_if.sv */
// Configuration write channel.
`default_nettype none

interface pdrt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pdrt_pkg::CFG_INDEX_W-1:0] index;
    logic [pdrt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pdrt_debounce.sv */
// Presence debounce state, state age counter and presence report.
`default_nettype none

module pdrt_debounce (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          tick_en,
    input  wire logic                          alive,
    input  wire logic                          raw_in,
    input  wire logic [pdrt_pkg::PEND_W-1:0]   debounce_ticks,
    output logic [1:0]                         rep_next,
    output logic                               first_sample,
    output logic                               debounced,
    output logic [pdrt_pkg::AGE_W-1:0]         state_age,
    output logic [pdrt_pkg::AGE_W-1:0]         present_seconds
);
    import pdrt_pkg::*;

    logic              seen_reg, seen_next;
    logic              deb_reg, deb_next;
    logic              pend_reg, pend_next;
    logic [PEND_W-1:0] page_reg, page_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic              raw;
    logic [PEND_W-1:0] page_step;

    assign raw          = alive & raw_in;
    assign first_sample = alive & ~seen_reg;

    // Work out the state after one tick
    always_comb
    begin
        seen_next = seen_reg;
        deb_next  = deb_reg;
        pend_next = pend_reg;
        page_next = page_reg;
        age_next  = age_reg;
        rep_next  = REP_NONE;
        page_step = '0;
        if (!alive)
        begin
            seen_next = 1'b0;
            deb_next  = 1'b0;
            pend_next = 1'b0;
            page_next = '0;
            age_next  = '0;
            rep_next  = seen_reg ? REP_UNAVAIL : REP_NONE;
        end
        else if (!seen_reg)
        begin
            seen_next = 1'b1;
            deb_next  = raw;
            pend_next = 1'b0;
            page_next = '0;
            age_next  = '0;
            rep_next  = raw ? REP_PRESENT : REP_ABSENT;
        end
        else
        begin
            // Saturating age increment
            if (age_reg != '1)
                age_next = age_reg + AGE_W'(1);
            if (raw == deb_reg)
            begin
                pend_next = 1'b0;
                page_next = '0;
            end
            else
            begin
                if (!pend_reg)
                    page_step = '0;
                else if (page_reg != '1)
                    page_step = page_reg + PEND_W'(1);
                else
                    page_step = page_reg;
                pend_next = 1'b1;
                page_next = page_step;
                // Flip, backdating the age to the start of the disagreement
                if (page_step >= debounce_ticks)
                begin
                    deb_next  = raw;
                    age_next  = AGE_W'(page_step);
                    pend_next = 1'b0;
                    page_next = '0;
                    rep_next  = raw ? REP_PRESENT : REP_ABSENT;
                end
            end
        end
    end

    // Hold the state between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            deb_reg  <= 1'b0;
            pend_reg <= 1'b0;
            page_reg <= '0;
            age_reg  <= '0;
        end
        else if (tick_en)
        begin
            seen_reg <= seen_next;
            deb_reg  <= deb_next;
            pend_reg <= pend_next;
            page_reg <= page_next;
            age_reg  <= age_next;
        end
    end

    assign debounced       = deb_reg;
    assign state_age       = age_reg;
    assign present_seconds = (seen_reg && deb_reg) ? age_reg : '0;

endmodule

`default_nettype wire

/* hw/rtl/pdrt_rule_unit.sv */
// Rule table, armed flags and the shared per-slot rule evaluator.
`default_nettype none

module pdrt_rule_unit #(
    parameter int RULES = pdrt_pkg::RULES_DEFAULT,
    parameter int IDX_W = 3,
    parameter int CNT_W = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pdrt_pkg::rule_ctl_t           ctl,
    input  wire logic [pdrt_pkg::SLOT_W-1:0]   wr_idx,
    input  wire pdrt_pkg::rule_t               wr_rule,
    input  wire logic [CNT_W-1:0]              arm_cnt,
    input  wire logic [IDX_W-1:0]              step_idx,
    input  wire logic                          debounced,
    input  wire logic [pdrt_pkg::AGE_W-1:0]    state_age,
    input  wire logic                          link_ready,
    output logic                               fire,
    output logic [pdrt_pkg::TARGET_W-1:0]      fire_target
);
    import pdrt_pkg::*;

    rule_t            table_reg [RULES];
    logic [RULES-1:0] armed_reg, armed_next;
    rule_t            entry;
    logic             active;
    logic             due;
    logic [5:0]       wr_ext;
    logic             wr_ok;
    logic [IDX_W-1:0] wr_addr;

    // Evaluate the slot under the walk index
    assign entry       = table_reg[step_idx];
    assign active      = entry.on_absence ? ~debounced : debounced;
    assign due         = {{(AGE_W-DUR_W){1'b0}}, entry.duration} <= state_age;
    assign fire        = entry.enabled & active & armed_reg[step_idx] & due & link_ready;
    assign fire_target = entry.target;

    // Drop writes to slots beyond the table
    assign wr_ext  = {3'b000, wr_idx};
    assign wr_ok   = wr_ext < 6'(RULES);
    assign wr_addr = IDX_W'(wr_ext);

    // Re-arm on load or sensor change, update the walked slot
    always_comb
    begin
        armed_next = armed_reg;
        for (int i = 0; i < RULES; i++)
        begin
            if (ctl.arm_all)
                armed_next[i] = 1'b1;
            else if (ctl.arm_first && (CNT_W'(i) < arm_cnt))
                armed_next[i] = 1'b1;
            else if (ctl.step_en && (step_idx == IDX_W'(i)) && entry.enabled)
            begin
                if (!active)
                    armed_next[i] = 1'b1;
                else if (fire)
                    armed_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            armed_reg <= '1;
        else
            armed_reg <= armed_next;
    end

    // Write one rule slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RULES; i++)
                table_reg[i] <= '0;
        end
        else if (ctl.wr_en && wr_ok)
        begin
            table_reg[wr_addr] <= wr_rule;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/presence_debounce_rule_trigger.sv */
// Top level: sequencer, configuration registers and result register.
//
//   channel | role  | handshake   | carries
//   --------+-------+-------------+---------------------------------------------
//   req     | sink  | valid/ready | tick sample or one rule slot load
//   rsp     | source| valid/ready | report, fired rules, load acknowledgement
//   cfg     | sink  | valid/ready | debounce_ticks (index 0), rule_count (1)
//
// A load goes from idle straight to the flush state. A tick walks N slots,
// N = min(rule_count, RULES), in the one shared rule evaluator that visits
// one slot per cycle unless stalled; a tick from an offline sensor walks none.
// req.ready is high only while the sequencer is idle; cfg.ready is always high.
// A stall on rsp holds the walk at the next firing slot until the result
// register frees. Reset clears all but the payload registers; no clearing pass.
`default_nettype none

module presence_debounce_rule_trigger #(
    parameter int RULES = pdrt_pkg::RULES_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pdrt_req_if.sink   req,
    pdrt_rsp_if.source rsp,
    pdrt_cfg_if.sink   cfg
);
    import pdrt_pkg::*;

    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W = $clog2(RULES + 1);

    state_t              state_reg, state_next;
    logic [PEND_W-1:0]   debounce_ticks_reg;
    logic [RC_W-1:0]     rule_count_reg;
    logic [CNT_W-1:0]    walk_idx_reg, walk_idx_next;
    logic                link_reg, link_next;
    logic [1:0]          hold_kind_reg, hold_kind_next;
    logic [1:0]          hold_rep_reg, hold_rep_next;
    logic [SLOT_W-1:0]   hold_slot_reg, hold_slot_next;
    logic [TARGET_W-1:0] hold_target_reg, hold_target_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [1:0]          out_rep_reg, out_rep_next;
    logic                out_deb_reg, out_deb_next;
    logic [AGE_W-1:0]    out_secs_reg, out_secs_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [TARGET_W-1:0] out_target_reg, out_target_next;
    logic                out_last_reg, out_last_next;

    logic                acc;
    logic                can_push;
    logic                step_adv;
    logic [5:0]          rc_ext;
    logic [CNT_W-1:0]    cnt;
    rule_ctl_t           ctl;
    rule_t               wr_rule;
    logic                tick_en;
    logic [1:0]          db_rep;
    logic                db_first;
    logic                db_deb;
    logic [AGE_W-1:0]    db_age;
    logic [AGE_W-1:0]    db_secs;
    logic                rule_fire;
    logic [TARGET_W-1:0] rule_target;

    // Effective rule count
    assign rc_ext = {2'b00, rule_count_reg};
    assign cnt    = (rc_ext >= 6'(RULES)) ? CNT_W'(RULES) : CNT_W'(rc_ext);

    assign acc       = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign can_push  = !out_valid_reg || rsp.ready;
    assign step_adv  = (state_reg == ST_WALK) && (!rule_fire || can_push);
    assign cfg.ready = 1'b1;

    assign wr_rule.enabled    = req.slot_enabled;
    assign wr_rule.on_absence = req.slot_on_absence;
    assign wr_rule.duration   = req.slot_duration;
    assign wr_rule.target     = req.slot_target;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
            rule_count_reg     <= RULE_COUNT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_DEBOUNCE:   debounce_ticks_reg <= cfg.data;
                CFG_RULE_COUNT: rule_count_reg     <= cfg.data[RC_W-1:0];
                default:        ;
            endcase
        end
    end

    pdrt_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_en        (tick_en),
        .alive          (req.sensor_alive),
        .raw_in         (req.sensor_raw),
        .debounce_ticks (debounce_ticks_reg),
        .rep_next       (db_rep),
        .first_sample   (db_first),
        .debounced      (db_deb),
        .state_age      (db_age),
        .present_seconds(db_secs)
    );

    pdrt_rule_unit #(
        .RULES(RULES),
        .IDX_W(IDX_W),
        .CNT_W(CNT_W)
    ) u_rule_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .wr_idx     (req.slot_index),
        .wr_rule    (wr_rule),
        .arm_cnt    (cnt),
        .step_idx   (walk_idx_reg[IDX_W-1:0]),
        .debounced  (db_deb),
        .state_age  (db_age),
        .link_ready (link_reg),
        .fire       (rule_fire),
        .fire_target(rule_target)
    );

    // Sequencer: accept, walk the slots, flush the held result
    always_comb
    begin
        state_next       = state_reg;
        walk_idx_next    = walk_idx_reg;
        link_next        = link_reg;
        hold_kind_next   = hold_kind_reg;
        hold_rep_next    = hold_rep_reg;
        hold_slot_next   = hold_slot_reg;
        hold_target_next = hold_target_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_rep_next     = out_rep_reg;
        out_deb_next     = out_deb_reg;
        out_secs_next    = out_secs_reg;
        out_slot_next    = out_slot_reg;
        out_target_next  = out_target_reg;
        out_last_next    = out_last_reg;
        ctl              = '0;
        tick_en          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (req.cmd == CMD_LOAD)
                    begin
                        ctl.wr_en        = 1'b1;
                        ctl.arm_all      = 1'b1;
                        hold_kind_next   = KIND_ACK;
                        hold_rep_next    = REP_NONE;
                        hold_slot_next   = req.slot_index;
                        hold_target_next = req.slot_target;
                        state_next       = ST_FLUSH;
                    end
                    else
                    begin
                        tick_en          = 1'b1;
                        link_next        = req.link_ready;
                        hold_kind_next   = KIND_REPORT;
                        hold_rep_next    = db_rep;
                        hold_slot_next   = '0;
                        hold_target_next = '0;
                        ctl.arm_first    = !req.sensor_alive || db_first;
                        walk_idx_next    = '0;
                        if (!req.sensor_alive || (cnt == '0))
                            state_next = ST_FLUSH;
                        else
                            state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (step_adv)
                begin
                    ctl.step_en = 1'b1;
                    // Push the held result out and hold the fired one
                    if (rule_fire)
                    begin
                        out_valid_next   = 1'b1;
                        out_kind_next    = hold_kind_reg;
                        out_rep_next     = hold_rep_reg;
                        out_deb_next     = db_deb;
                        out_secs_next    = db_secs;
                        out_slot_next    = hold_slot_reg;
                        out_target_next  = hold_target_reg;
                        out_last_next    = 1'b0;
                        hold_kind_next   = KIND_FIRE;
                        hold_rep_next    = REP_NONE;
                        hold_slot_next   = SLOT_W'(walk_idx_reg);
                        hold_target_next = rule_target;
                    end
                    if (walk_idx_reg == (cnt - CNT_W'(1)))
                        state_next = ST_FLUSH;
                    else
                        walk_idx_next = walk_idx_reg + CNT_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (can_push)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = hold_kind_reg;
                    out_rep_next    = hold_rep_reg;
                    out_deb_next    = db_deb;
                    out_secs_next   = db_secs;
                    out_slot_next   = hold_slot_reg;
                    out_target_next = hold_target_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            walk_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            walk_idx_reg  <= walk_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        link_reg        <= link_next;
        hold_kind_reg   <= hold_kind_next;
        hold_rep_reg    <= hold_rep_next;
        hold_slot_reg   <= hold_slot_next;
        hold_target_reg <= hold_target_next;
        out_kind_reg    <= out_kind_next;
        out_rep_reg     <= out_rep_next;
        out_deb_reg     <= out_deb_next;
        out_secs_reg    <= out_secs_next;
        out_slot_reg    <= out_slot_next;
        out_target_reg  <= out_target_next;
        out_last_reg    <= out_last_next;
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.kind              = out_kind_reg;
    assign rsp.presence_report   = out_rep_reg;
    assign rsp.debounced_present = out_deb_reg;
    assign rsp.present_seconds   = out_secs_reg;
    assign rsp.fired_slot        = out_slot_reg;
    assign rsp.fired_target      = out_target_reg;
    assign rsp.last              = out_last_reg;

    // The walk index stays inside the effective rule count
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (walk_idx_reg < cnt))
        else $error("walk index beyond rule count");

    // A flush that pushes leaves a final result in the output register
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FLUSH) && can_push) |=> (out_valid_reg && out_last_reg))
        else $error("flush did not deliver a final result");

    // A rule fires only while the sampled link is ready
    a_fire_link: assert property (@(posedge clk) disable iff (!rst_n)
        (step_adv && rule_fire) |-> link_reg)
        else $error("rule fired with link down");

    // A load goes straight to its acknowledgement
    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req.cmd == CMD_LOAD)) |=> ((state_reg == ST_FLUSH) &&
                                            (hold_kind_reg == KIND_ACK)))
        else $error("load not acknowledged");

endmodule

`default_nettype wire
